// File: rtl/fot_pkg.sv
// Shared types and constants for the frequency-ordered table.
`timescale 1ns / 1ps
`default_nettype none
package fot_pkg;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_ACCESS = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } fot_state_t;

  typedef struct packed {
    logic capture;
    logic search;
    logic update;
  } fot_cmd_t;

endpackage
`default_nettype wire

// File: rtl/frequency_ordered_table.sv
// Top level of the frequency-ordered table: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// A request is taken when start is high and busy is low. The key is compared
// against all entries in parallel in the cycle after the request, and the
// entries are reordered and written in the cycle after that; busy is high
// only in the compare cycle. The result is shown for exactly one cycle with
// out_valid high, in the cycle after the update, and must be taken then; the
// next request can already be taken in the update cycle. The entry storage
// comes up empty after reset with no clearing pass.
module frequency_ordered_table #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_req_type,
  input  wire logic signed [31:0]             in_key,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [$clog2(ENTRIES)-1:0]          out_old_position,
  output logic [$clog2(ENTRIES)-1:0]          out_new_position,
  output logic [COUNT_WIDTH-1:0]              out_count_value,
  output logic                                out_table_full,
  output logic [$clog2(ENTRIES+1)-1:0]        out_occupancy
);
  import fot_pkg::*;

  fot_cmd_t cmd;

  fot_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  fot_datapath #(
    .ENTRIES     (ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_req_type      (in_req_type),
    .in_key           (in_key),
    .out_hit          (out_hit),
    .out_old_position (out_old_position),
    .out_new_position (out_new_position),
    .out_count_value  (out_count_value),
    .out_table_full   (out_table_full),
    .out_occupancy    (out_occupancy)
  );

endmodule
`default_nettype wire

// File: rtl/fot_ctrl.sv
// Controller state machine that sequences capture, search and update of a request.
`timescale 1ns / 1ps
`default_nettype none
module fot_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output fot_pkg::fot_cmd_t     cmd,
  output logic                  out_valid
);
  import fot_pkg::*;

  fot_state_t state_r, state_nxt;
  logic       out_valid_r;
  logic       accept;

  assign busy   = (state_r == ST_SEARCH);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = accept ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_UPDATE);
    end
  end

  assign cmd.capture = accept;
  assign cmd.search  = (state_r == ST_SEARCH);
  assign cmd.update  = (state_r == ST_UPDATE);
  assign out_valid   = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/fot_datapath.sv
// Datapath holding the entry registers, the parallel key search and the reorder logic.
`timescale 1ns / 1ps
`default_nettype none
module fot_datapath #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire fot_pkg::fot_cmd_t                cmd,
  input  wire logic [1:0]                       in_req_type,
  input  wire logic [31:0]                      in_key,
  output logic                                  out_hit,
  output logic [$clog2(ENTRIES)-1:0]            out_old_position,
  output logic [$clog2(ENTRIES)-1:0]            out_new_position,
  output logic [COUNT_WIDTH-1:0]                out_count_value,
  output logic                                  out_table_full,
  output logic [$clog2(ENTRIES+1)-1:0]          out_occupancy
);
  import fot_pkg::*;

  localparam int POS_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_TOP = {COUNT_WIDTH{1'b1}};

  logic [31:0]          key_r   [ENTRIES];
  logic [31:0]          key_nxt [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_r   [ENTRIES];
  logic [COUNT_WIDTH-1:0] cnt_nxt [ENTRIES];
  logic [OCC_W-1:0]     total_r, total_nxt;

  logic [1:0]           req_type_r;
  logic [31:0]          req_key_r;

  logic                 found_r;
  logic [ENTRIES-1:0]   match_oh_r;
  logic [POS_W-1:0]     match_pos_r;
  logic [COUNT_WIDTH-1:0] match_cnt_r;

  logic                 hit_r, hit_nxt;
  logic [POS_W-1:0]     oldp_r, oldp_nxt;
  logic [POS_W-1:0]     newp_r, newp_nxt;
  logic [COUNT_WIDTH-1:0] cnt_out_r, cnt_out_nxt;
  logic                 full_out_r, full_out_nxt;

  logic [ENTRIES-1:0]   eq;
  logic [ENTRIES-1:0]   eq_first;
  logic [POS_W-1:0]     srch_pos;
  logic [COUNT_WIDTH-1:0] srch_cnt;

  logic [COUNT_WIDTH-1:0] new_cnt;
  logic [ENTRIES-1:0]   below_a;
  logic [ENTRIES-1:0]   le;
  logic [ENTRIES-1:0]   le_first;
  logic [ENTRIES-1:0]   tgt;
  logic [ENTRIES-1:0]   shift_mask;
  logic [POS_W-1:0]     tgt_pos;
  logic                 is_full;

  // Parallel compare of the request key against every valid entry.
  always_comb begin
    srch_pos = '0;
    srch_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      eq[i] = (OCC_W'(i) < total_r) && (key_r[i] == req_key_r);
    end
    eq_first = eq & (~eq + ENTRIES'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      if (eq_first[i]) begin
        srch_pos = srch_pos | POS_W'(i);
        srch_cnt = srch_cnt | cnt_r[i];
      end
    end
  end

  // The first entry ahead of the match whose count does not exceed the new count.
  always_comb begin
    new_cnt = (match_cnt_r == CNT_TOP) ? match_cnt_r : match_cnt_r + 1'b1;
    below_a = match_oh_r - ENTRIES'(1);
    for (int i = 0; i < ENTRIES; i++) begin
      le[i] = below_a[i] && (cnt_r[i] <= new_cnt);
    end
    le_first   = le & (~le + ENTRIES'(1));
    tgt        = (|le) ? le_first : match_oh_r;
    shift_mask = (match_oh_r | below_a) & ~(tgt | (tgt - ENTRIES'(1)));
    tgt_pos    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt[i]) tgt_pos = tgt_pos | POS_W'(i);
    end
    is_full = (total_r == OCC_W'(ENTRIES));
  end

  always_comb begin
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    total_nxt    = total_r;
    hit_nxt      = 1'b0;
    oldp_nxt     = '0;
    newp_nxt     = '0;
    cnt_out_nxt  = '0;
    full_out_nxt = 1'b0;
    case (req_type_r)
      REQ_APPEND: begin
        if (is_full) begin
          full_out_nxt = 1'b1;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (OCC_W'(i) == total_r) begin
              key_nxt[i] = req_key_r;
              cnt_nxt[i] = '0;
            end
          end
          newp_nxt  = total_r[POS_W-1:0];
          total_nxt = total_r + 1'b1;
        end
      end
      REQ_ACCESS: begin
        if (found_r) begin
          for (int i = 1; i < ENTRIES; i++) begin
            if (shift_mask[i]) begin
              key_nxt[i] = key_r[i-1];
              cnt_nxt[i] = cnt_r[i-1];
            end
          end
          for (int i = 0; i < ENTRIES; i++) begin
            if (tgt[i]) begin
              key_nxt[i] = req_key_r;
              cnt_nxt[i] = new_cnt;
            end
          end
          hit_nxt     = 1'b1;
          oldp_nxt    = match_pos_r;
          newp_nxt    = tgt_pos;
          cnt_out_nxt = new_cnt;
        end
      end
      REQ_REMOVE: begin
        if (found_r) begin
          for (int i = 0; i < ENTRIES - 1; i++) begin
            if (!below_a[i]) begin
              key_nxt[i] = key_r[i+1];
              cnt_nxt[i] = cnt_r[i+1];
            end
          end
          total_nxt = total_r - 1'b1;
          hit_nxt   = 1'b1;
          oldp_nxt  = match_pos_r;
        end
      end
      default: begin
        hit_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.update) begin
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= in_req_type;
      req_key_r  <= in_key;
    end
    if (cmd.search) begin
      found_r     <= |eq;
      match_oh_r  <= eq_first;
      match_pos_r <= srch_pos;
      match_cnt_r <= srch_cnt;
    end
    if (cmd.update) begin
      key_r      <= key_nxt;
      cnt_r      <= cnt_nxt;
      hit_r      <= hit_nxt;
      oldp_r     <= oldp_nxt;
      newp_r     <= newp_nxt;
      cnt_out_r  <= cnt_out_nxt;
      full_out_r <= full_out_nxt;
    end
  end

  assign out_hit          = hit_r;
  assign out_old_position = oldp_r;
  assign out_new_position = newp_r;
  assign out_count_value  = cnt_out_r;
  assign out_table_full   = full_out_r;
  assign out_occupancy    = total_r;

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the frequency-ordered table with a scoreboard class.
`timescale 1ns / 1ps
module testbench;
  import fot_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int POS_W       = $clog2(ENTRIES);
  localparam int OCC_W       = $clog2(ENTRIES + 1);
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_REQUESTS = 330;
  localparam int BURST_LEN = 48;

  typedef struct packed {
    logic                   hit;
    logic [POS_W-1:0]       old_position;
    logic [POS_W-1:0]       new_position;
    logic [COUNT_WIDTH-1:0] count_value;
    logic                   table_full;
    logic [OCC_W-1:0]       occupancy;
  } table_result_t;

  class order_scoreboard;
    logic [31:0]            key_tab[ENTRIES];
    logic [COUNT_WIDTH-1:0] count_tab[ENTRIES];
    int unsigned            total;
    int unsigned            failures;
    table_result_t          expected_q[$];

    function new();
      total = 0;
      failures = 0;
    endfunction

    function void note_request(logic [1:0] req_type, logic [31:0] key);
      table_result_t          r;
      int                     found;
      int                     slot;
      logic [COUNT_WIDTH-1:0] bumped;
      logic [31:0]            moved_key;
      r = '0;
      found = -1;
      for (int i = 0; i < total; i++) begin
        if (found < 0 && key_tab[i] == key) found = i;
      end
      case (req_type)
        REQ_APPEND: begin
          if (total < ENTRIES) begin
            key_tab[total] = key;
            count_tab[total] = '0;
            r.new_position = POS_W'(total);
            total++;
          end else begin
            r.table_full = 1'b1;
          end
        end
        REQ_ACCESS: begin
          if (found >= 0) begin
            bumped = count_tab[found];
            if (bumped != '1) bumped++;
            count_tab[found] = bumped;
            moved_key = key_tab[found];
            slot = found;
            for (int i = 0; i < found; i++) begin
              if (slot == found && count_tab[i] <= bumped) slot = i;
            end
            for (int i = found; i > slot; i--) begin
              key_tab[i] = key_tab[i-1];
              count_tab[i] = count_tab[i-1];
            end
            key_tab[slot] = moved_key;
            count_tab[slot] = bumped;
            r.hit = 1'b1;
            r.old_position = POS_W'(found);
            r.new_position = POS_W'(slot);
            r.count_value = bumped;
          end
        end
        REQ_REMOVE: begin
          if (found >= 0) begin
            for (int i = found; i + 1 < total; i++) begin
              key_tab[i] = key_tab[i+1];
              count_tab[i] = count_tab[i+1];
            end
            total--;
            r.hit = 1'b1;
            r.old_position = POS_W'(found);
          end
        end
        default: ;
      endcase
      r.occupancy = OCC_W'(total);
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        failures++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t exp;
      if (expected_q.size() == 0) begin
        $error("Result arrived with no request outstanding.");
        failures++;
        return;
      end
      exp = expected_q.pop_front();
      compare_field("hit", 32'(exp.hit), 32'(got.hit));
      compare_field("old_position", 32'(exp.old_position), 32'(got.old_position));
      compare_field("new_position", 32'(exp.new_position), 32'(got.new_position));
      compare_field("count_value", 32'(exp.count_value), 32'(got.count_value));
      compare_field("table_full", 32'(exp.table_full), 32'(got.table_full));
      compare_field("occupancy", 32'(exp.occupancy), 32'(got.occupancy));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived.", expected_q.size());
        failures++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    in_req_type = REQ_APPEND;
  logic signed [31:0]            in_key = '0;
  logic                          out_valid;
  logic                          out_hit;
  logic [POS_W-1:0]              out_old_position;
  logic [POS_W-1:0]              out_new_position;
  logic [COUNT_WIDTH-1:0]        out_count_value;
  logic                          out_table_full;
  logic [OCC_W-1:0]              out_occupancy;

  order_scoreboard sb = new();
  int              sender_idle_pct = 0;
  int              stall_cycles = 0;
  logic [31:0]     key_pool[8];

  frequency_ordered_table #(
    .ENTRIES    (ENTRIES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_old_position(out_old_position),
    .out_new_position(out_new_position),
    .out_count_value (out_count_value),
    .out_table_full  (out_table_full),
    .out_occupancy   (out_occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result({out_hit, out_old_position, out_new_position, out_count_value,
                       out_table_full, out_occupancy});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_request(input logic [1:0] req_type, input logic [31:0] key);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    in_req_type <= req_type;
    in_key <= key;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(req_type, key);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [1:0] pick_request(bit growing);
    int unsigned r;
    r = $urandom_range(99);
    if (growing) begin
      if (r < 45) return REQ_APPEND;
      if (r < 80) return REQ_ACCESS;
      if (r < 96) return REQ_REMOVE;
    end else begin
      if (r < 15) return REQ_APPEND;
      if (r < 55) return REQ_ACCESS;
      if (r < 95) return REQ_REMOVE;
    end
    return REQ_UNUSED;
  endfunction

  function automatic logic [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (sb.total > 0 && r < 55) return sb.key_tab[$urandom_range(sb.total - 1)];
    if (r < 85) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  initial begin
    int   idle_plan[5];
    bit   growing;
    idle_plan = '{0, 69, 17, 0, 69};
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Misses and the unused code on an empty table, ordering by count, then a full table.
    send_request(REQ_ACCESS, 32'h1234_5678);
    send_request(REQ_REMOVE, 32'h1234_5678);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF);
    send_request(REQ_APPEND, 32'h8000_0000);
    send_request(REQ_APPEND, 32'h7FFF_FFFF);
    send_request(REQ_APPEND, 32'h0000_0000);
    send_request(REQ_APPEND, 32'hFFFF_FFFF);
    send_request(REQ_APPEND, 32'h8000_0000);
    send_request(REQ_ACCESS, 32'h7FFF_FFFF);
    send_request(REQ_ACCESS, 32'h7FFF_FFFF);
    send_request(REQ_ACCESS, 32'hFFFF_FFFF);
    send_request(REQ_ACCESS, 32'h8000_0000);
    send_request(REQ_ACCESS, 32'h1234_5678);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF);
    send_request(REQ_REMOVE, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h1234_5678);
    while (sb.total < ENTRIES) begin
      send_request(REQ_APPEND, sb.total[0] ? 32'hAAAA_AAAA : 32'h5555_5555);
    end
    send_request(REQ_APPEND, 32'h0F0F_0F0F);
    send_request(REQ_UNUSED, 32'h0000_0000);
    wait_for_results();

    foreach (idle_plan[p]) begin
      sender_idle_pct = idle_plan[p];
      growing = 1'b1;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n % BURST_LEN == 0) growing = $urandom_range(1);
        send_request(pick_request(growing), pick_key());
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: sim.f
rtl/fot_pkg.sv
rtl/fot_ctrl.sv
rtl/fot_datapath.sv
rtl/frequency_ordered_table.sv
tb/sv/testbench.sv
